### design/plc_pkg.sv
package plc_pkg;

   localparam int OP_W        = 2;
   localparam int VAL_W       = 32;
   localparam int POS_W       = 5;
   localparam int STAT_W      = 2;
   localparam int CNT_OUT_W   = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_OOB   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef enum logic [2:0] {
      SEL_HOLD,
      SEL_NEW,
      SEL_PREV,
      SEL_NEXT,
      SEL_HEAD
   } cell_sel_type;

   typedef enum logic [1:0] {
      CH_HOLD,
      CH_INSERT,
      CH_DELETE,
      CH_ROTATE
   } chain_kind_type;

   typedef struct packed {
      chain_kind_type     kind;
      logic [POS_W-1:0]   pos;
   } chain_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } state_type;

endpackage

### design/plc_cell.sv
module plc_cell (
   input  logic                            clock,
   input  plc_pkg::cell_sel_type           sel,
   input  logic signed [plc_pkg::VAL_W-1:0] prev_data,
   input  logic signed [plc_pkg::VAL_W-1:0] next_data,
   input  logic signed [plc_pkg::VAL_W-1:0] side_data,
   output logic signed [plc_pkg::VAL_W-1:0] data_out
);

   logic signed [plc_pkg::VAL_W-1:0] data_ff;
   logic signed [plc_pkg::VAL_W-1:0] data_in;

   always_comb begin
      unique case (sel)
         plc_pkg::SEL_NEW:  data_in = side_data;
         plc_pkg::SEL_HEAD: data_in = side_data;
         plc_pkg::SEL_PREV: data_in = prev_data;
         plc_pkg::SEL_NEXT: data_in = next_data;
         default:           data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### design/plc_chain.sv
module plc_chain #(
   parameter int CAPACITY = 16,
   localparam int CNT_W = $clog2(CAPACITY + 1),
   localparam int CMP_W = (CNT_W > plc_pkg::POS_W) ? CNT_W : plc_pkg::POS_W
) (
   input  logic                             clock,
   input  plc_pkg::chain_cmd_type           cmd,
   input  logic [CNT_W-1:0]                 count,
   input  logic signed [plc_pkg::VAL_W-1:0] value,
   output logic signed [plc_pkg::VAL_W-1:0] head_data
);

   logic signed [plc_pkg::VAL_W-1:0] cell_data [CAPACITY];
   logic signed [plc_pkg::VAL_W-1:0] side_data;
   logic [CMP_W-1:0]                 pos_x;
   logic [CMP_W-1:0]                 cnt_x;

   assign pos_x     = CMP_W'(cmd.pos);
   assign cnt_x     = CMP_W'(count);
   assign head_data = cell_data[0];
   assign side_data = (cmd.kind == plc_pkg::CH_INSERT) ? value : cell_data[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX      = CMP_W'(i);
      localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(i + 1);
      plc_pkg::cell_sel_type            sel;
      logic signed [plc_pkg::VAL_W-1:0] prev_w;
      logic signed [plc_pkg::VAL_W-1:0] next_w;

      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid_lo
         assign prev_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_mid_hi
         assign next_w = cell_data[i+1];
      end

      always_comb begin
         sel = plc_pkg::SEL_HOLD;
         unique case (cmd.kind)
            plc_pkg::CH_INSERT: begin
               if (IDX == pos_x) begin
                  sel = plc_pkg::SEL_NEW;
               end else if (IDX > pos_x && IDX <= cnt_x) begin
                  sel = plc_pkg::SEL_PREV;
               end
            end
            plc_pkg::CH_DELETE: begin
               if (IDX >= pos_x && IDX_NEXT < cnt_x) begin
                  sel = plc_pkg::SEL_NEXT;
               end
            end
            plc_pkg::CH_ROTATE: begin
               if (IDX_NEXT < cnt_x) begin
                  sel = plc_pkg::SEL_NEXT;
               end else if (IDX_NEXT == cnt_x) begin
                  sel = plc_pkg::SEL_HEAD;
               end
            end
            default: sel = plc_pkg::SEL_HOLD;
         endcase
      end

      plc_cell u_cell (
         .clock     (clock),
         .sel       (sel),
         .prev_data (prev_w),
         .next_data (next_w),
         .side_data (side_data),
         .data_out  (cell_data[i])
      );
   end

endmodule

### design/positional_list_insert_delete_core.sv
// bounded ordered list of signed 32-bit values held in a row of shifting cells
// req channel: one item per operation (insert, delete or read-all)
// rsp channel: insert, delete and unknown ops give one item each; read-all gives
//   one item per element in list order with tlast on the final one, or a single
//   item with no value when the list is empty
// insert, delete, unknown ops and an empty read-all register their item in the cycle
//   after the request is taken; a read-all first enters its read state, and each
//   element is then registered from the chain head when the output register is free;
// insert and delete move all cells at once; during a read-all the chain rotates one
//   place per result and is back in order when the last element leaves
// a new request is taken only when the output register is empty or being
//   drained and no read-all is in progress
// a stalled rsp holds its item and the chain stops rotating until it is taken
// reset empties the list and drops any pending result; element values are
//   never cleared, only the count
module positional_list_insert_delete_core #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op[1:0], value[33:2], position[38:34], zero fill
   input  logic [plc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // element[31:0], count[36:32], zero fill
   output logic [plc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status[1:0], has_value[2]
   output logic [plc_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > plc_pkg::POS_W) ? CNT_W : plc_pkg::POS_W;
   localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

   logic [plc_pkg::OP_W-1:0]          req_op;
   logic signed [plc_pkg::VAL_W-1:0]  req_value;
   logic [plc_pkg::POS_W-1:0]         req_position;

   plc_pkg::state_type                state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [plc_pkg::STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                              rsp_has_ff, rsp_has_in;
   logic signed [plc_pkg::VAL_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [plc_pkg::CNT_OUT_W-1:0]     rsp_count_ff, rsp_count_in;

   plc_pkg::chain_cmd_type            cmd;
   logic signed [plc_pkg::VAL_W-1:0]  head_data;
   logic [CMP_W-1:0]                  pos_x;
   logic [CMP_W-1:0]                  cnt_x;
   logic [CMP_W-1:0]                  cnt_next_x;
   logic [CMP_W-1:0]                  rd_next_x;
   logic                              out_free;
   logic                              accept;

   assign req_op       = req_tdata[1:0];
   assign req_value    = req_tdata[33:2];
   assign req_position = req_tdata[38:34];

   assign pos_x      = CMP_W'(req_position);
   assign cnt_x      = CMP_W'(count_ff);
   assign cnt_next_x = CMP_W'(count_in);
   assign rd_next_x  = CMP_W'(rd_idx_ff) + CMP_W'(1);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == plc_pkg::FSM_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic load;
      load          = 1'b0;
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = plc_pkg::ST_OK;
      rsp_has_in    = 1'b0;
      rsp_elem_in   = '0;
      rsp_last_in   = 1'b1;
      cmd.kind      = plc_pkg::CH_HOLD;
      cmd.pos       = req_position;
      unique case (state_ff)
         plc_pkg::FSM_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  plc_pkg::OP_INSERT: begin
                     load = 1'b1;
                     if (pos_x > cnt_x) begin
                        rsp_status_in = plc_pkg::ST_OOB;
                     end else if (cnt_x >= CAP_X) begin
                        rsp_status_in = plc_pkg::ST_FULL;
                     end else begin
                        cmd.kind = plc_pkg::CH_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  plc_pkg::OP_DELETE: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = plc_pkg::ST_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        rsp_status_in = plc_pkg::ST_OOB;
                     end else begin
                        cmd.kind = plc_pkg::CH_DELETE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  plc_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        load = 1'b1;
                     end else begin
                        state_in  = plc_pkg::FSM_READ;
                        rd_idx_in = '0;
                     end
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         plc_pkg::FSM_READ: begin
            if (out_free) begin
               load        = 1'b1;
               cmd.kind    = plc_pkg::CH_ROTATE;
               rsp_has_in  = 1'b1;
               rsp_elem_in = head_data;
               rsp_last_in = (rd_next_x == cnt_x);
               if (rd_next_x == cnt_x) begin
                  state_in = plc_pkg::FSM_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = plc_pkg::FSM_IDLE;
      endcase
      rsp_count_in = cnt_next_x[plc_pkg::CNT_OUT_W-1:0];
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_status_in = rsp_status_ff;
         rsp_has_in    = rsp_has_ff;
         rsp_elem_in   = rsp_elem_ff;
         rsp_last_in   = rsp_last_ff;
         rsp_count_in  = rsp_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plc_pkg::FSM_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   plc_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .count     (count_ff),
      .value     (req_value),
      .head_data (head_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_has_ff, rsp_status_ff};
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_elem_ff};

endmodule

### design/plc_checker.sv
module plc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [plc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [plc_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input logic                             rsp_tlast
);

   // reset drops any pending item
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   // an item without a value is always the last of its request and carries a zero element
   a_novalue_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tlast && (rsp_tdata[31:0] == '0))
      else $error("no-value item not last or not zero");

   // element items always report ok
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == plc_pkg::ST_OK)
      else $error("element item with error status");

   // no new request while a read-all is still streaming
   a_no_req_mid_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] && !rsp_tlast |-> !req_tready)
      else $error("request taken during read-all");

endmodule

bind positional_list_insert_delete_core plc_checker u_plc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### tb/sv/positional_list_insert_delete_core_test.sv
`timescale 1ns / 1ps

module positional_list_insert_delete_core_test;

   localparam int CAP = 16;
   localparam int IDX_W = $clog2(CAP);
   localparam logic [plc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 150;

   typedef logic [plc_pkg::POS_W-1:0] pos_type;

   typedef struct {
      logic [plc_pkg::STAT_W-1:0]    status;
      logic                          has_value;
      logic [plc_pkg::VAL_W-1:0]     element;
      logic                          last;
      logic [plc_pkg::CNT_OUT_W-1:0] count;
   } list_rsp_type;

   typedef struct {
      logic [plc_pkg::OP_W-1:0]      op;
      logic [plc_pkg::VAL_W-1:0]     value;
      logic [plc_pkg::POS_W-1:0]     pos;
      bit                            known;
      logic [plc_pkg::STAT_W-1:0]    status;
      logic [plc_pkg::CNT_OUT_W-1:0] count;
   } list_step_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [plc_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [plc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [plc_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic rsp_tlast;

   logic [plc_pkg::VAL_W-1:0] model_cells [CAP];
   int unsigned model_count;
   list_rsp_type pending_rsp [$];
   list_step_type directed_steps [$];
   int error_count = 0;
   int cycle_count = 0;
   bit no_idle = 1'b0;

   positional_list_insert_delete_core #(
      .CAPACITY(CAP)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_idle();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic list_rsp_type single_rsp(logic [plc_pkg::STAT_W-1:0] st,
                                               int unsigned cnt);
      list_rsp_type r;
      r.status = st;
      r.has_value = 1'b0;
      r.element = '0;
      r.last = 1'b1;
      r.count = cnt[plc_pkg::CNT_OUT_W-1:0];
      return r;
   endfunction

   function automatic list_step_type step(logic [plc_pkg::OP_W-1:0] op,
                                          logic [plc_pkg::VAL_W-1:0] value,
                                          logic [plc_pkg::POS_W-1:0] pos,
                                          bit known = 1'b0,
                                          logic [plc_pkg::STAT_W-1:0] st = plc_pkg::ST_OK,
                                          logic [plc_pkg::CNT_OUT_W-1:0] cnt = '0);
      list_step_type s;
      s.op = op;
      s.value = value;
      s.pos = pos;
      s.known = known;
      s.status = st;
      s.count = cnt;
      return s;
   endfunction

   // updates the list copy and, when queue_rsp is set, queues the items the operation should produce
   task automatic predict_list_op(logic [plc_pkg::OP_W-1:0] op,
                                  logic [plc_pkg::VAL_W-1:0] value,
                                  logic [plc_pkg::POS_W-1:0] pos, bit queue_rsp);
      logic [plc_pkg::STAT_W-1:0] st;
      list_rsp_type r;
      st = plc_pkg::ST_OK;
      case (op)
         plc_pkg::OP_INSERT: begin
            if (pos > model_count) begin
               st = plc_pkg::ST_OOB;
            end else if (model_count >= CAP) begin
               st = plc_pkg::ST_FULL;
            end else begin
               for (int i = model_count; i > pos; i--)
                  model_cells[IDX_W'(i)] = model_cells[IDX_W'(i - 1)];
               model_cells[pos[IDX_W-1:0]] = value;
               model_count++;
            end
            if (queue_rsp) pending_rsp.push_back(single_rsp(st, model_count));
         end
         plc_pkg::OP_DELETE: begin
            if (model_count == 0) begin
               st = plc_pkg::ST_EMPTY;
            end else if (pos >= model_count) begin
               st = plc_pkg::ST_OOB;
            end else begin
               for (int i = pos; i + 1 < model_count; i++)
                  model_cells[IDX_W'(i)] = model_cells[IDX_W'(i + 1)];
               model_count--;
            end
            if (queue_rsp) pending_rsp.push_back(single_rsp(st, model_count));
         end
         plc_pkg::OP_READ: begin
            if (queue_rsp) begin
               if (model_count == 0) begin
                  pending_rsp.push_back(single_rsp(plc_pkg::ST_OK, 0));
               end else begin
                  for (int i = 0; i < model_count; i++) begin
                     r = single_rsp(plc_pkg::ST_OK, model_count);
                     r.has_value = 1'b1;
                     r.element = model_cells[IDX_W'(i)];
                     r.last = (i + 1 == model_count);
                     pending_rsp.push_back(r);
                  end
               end
            end
         end
         default: begin
            if (queue_rsp) pending_rsp.push_back(single_rsp(plc_pkg::ST_OK, model_count));
         end
      endcase
   endtask

   task automatic send_item(list_step_type s);
      int gap;
      gap = pick_idle();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, s.pos, s.value, s.op};
      do @(posedge clock); while (!req_tready);
      predict_list_op(s.op, s.value, s.pos, !s.known);
      if (s.known) pending_rsp.push_back(single_rsp(s.status, s.count));
   endtask

   task automatic report_mismatch(string what, list_rsp_type want, list_rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display({"%0t %s: expected st=%0d hv=%0b el=%h last=%0b cnt=%0d,",
                   " got st=%0d hv=%0b el=%h last=%0b cnt=%0d"},
                  $time, what, want.status, want.has_value, want.element, want.last,
                  want.count, got.status, got.has_value, got.element, got.last, got.count);
   endtask

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser[1:0];
         got.has_value = rsp_tuser[2];
         got.element = rsp_tdata[31:0];
         got.count = rsp_tdata[36:32];
         got.last = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", got, got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.has_value !== want.has_value ||
                got.element !== want.element || got.last !== want.last ||
                got.count !== want.count)
               report_mismatch("mismatch", want, got);
         end
      end
   end

   // receiver stalls
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_idle();
         end
      end
   end

   initial begin
      int unsigned lvl;
      int grow;
      logic [plc_pkg::OP_W-1:0] op;
      logic [plc_pkg::VAL_W-1:0] value;
      logic [plc_pkg::POS_W-1:0] pos;
      int r;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      model_count = 0;
      foreach (model_cells[i]) model_cells[i] = '0;

      directed_steps.push_back(step(plc_pkg::OP_READ, 32'h0, 5'd0, 1'b1,
                                    plc_pkg::ST_OK, 5'd0));
      directed_steps.push_back(step(plc_pkg::OP_DELETE, 32'h0, 5'd0, 1'b1,
                                    plc_pkg::ST_EMPTY, 5'd0));
      directed_steps.push_back(step(plc_pkg::OP_INSERT, 32'h5, 5'd1, 1'b1,
                                    plc_pkg::ST_OOB, 5'd0));
      directed_steps.push_back(step(plc_pkg::OP_INSERT, 32'h8000_0000, 5'd0, 1'b1,
                                    plc_pkg::ST_OK, 5'd1));
      directed_steps.push_back(step(plc_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1, 1'b1,
                                    plc_pkg::ST_OK, 5'd2));
      directed_steps.push_back(step(OP_UNUSED, 32'hFFFF_FFFF, 5'd31, 1'b1,
                                    plc_pkg::ST_OK, 5'd2));
      directed_steps.push_back(step(plc_pkg::OP_DELETE, 32'h0, 5'd2, 1'b1,
                                    plc_pkg::ST_OOB, 5'd2));
      directed_steps.push_back(step(plc_pkg::OP_READ, 32'h0, 5'd0));
      for (int i = 0; i < CAP - 2; i++)
         directed_steps.push_back(step(plc_pkg::OP_INSERT,
                                       32'h1234_5678 ^ (i * 32'h0F0F_1111),
                                       5'((i * 7) % (i + 3))));
      directed_steps.push_back(step(plc_pkg::OP_INSERT, 32'hFFFF_FFFF, 5'd16, 1'b1,
                                    plc_pkg::ST_FULL, 5'd16));
      directed_steps.push_back(step(plc_pkg::OP_INSERT, 32'h0, 5'd17, 1'b1,
                                    plc_pkg::ST_OOB, 5'd16));
      directed_steps.push_back(step(plc_pkg::OP_READ, 32'h0, 5'd0));
      directed_steps.push_back(step(plc_pkg::OP_DELETE, 32'h0, 5'd15));
      directed_steps.push_back(step(plc_pkg::OP_DELETE, 32'h0, 5'd0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) send_item(directed_steps[i]);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 85) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         no_idle = (k / 40 == 1);
         grow = (k / 40 == 3) ? 85 : 0;
         lvl = model_count;
         r = $urandom_range(99);
         if (r < 8) begin
            op = plc_pkg::OP_READ;
         end else if (r < 12) begin
            op = OP_UNUSED;
         end else begin
            if (grow == 0) grow = (lvl < 4) ? 75 : (lvl > 12) ? 30 : 55;
            op = ($urandom_range(99) < grow) ? plc_pkg::OP_INSERT : plc_pkg::OP_DELETE;
         end
         if ($urandom_range(99) < 85) begin
            if (op == plc_pkg::OP_INSERT) pos = pos_type'($urandom_range(lvl));
            else pos = (lvl > 0) ? pos_type'($urandom_range(lvl - 1)) : '0;
         end else begin
            pos = pos_type'($urandom_range(31));
         end
         case ($urandom_range(19))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'hFFFF_FFFF;
            3: value = 32'h0;
            default: value = $urandom;
         endcase
         send_item(step(op, value, pos));
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
